@@ rtl/core/ordered_key_value_table_defines.svh @@
// ----------------------------------------------------------------------------
// Ordered key-value table assertion macros
// Concurrent assertion wrappers; they expand to nothing in synthesis.
// ----------------------------------------------------------------------------
`ifndef ORDERED_KEY_VALUE_TABLE_DEFINES_SVH
`define ORDERED_KEY_VALUE_TABLE_DEFINES_SVH

`ifndef SYNTHESIS

// property must hold at every clock edge outside reset
`define OKVT_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("okvt assertion failed");

// condition must never be true outside reset
`define OKVT_ASSERT_NEVER(lbl, clk, rst_n, cond) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
		else $error("okvt forbidden condition seen");

`else

`define OKVT_ASSERT(lbl, clk, rst_n, prop)
`define OKVT_ASSERT_NEVER(lbl, clk, rst_n, cond)

`endif

`endif

@@ rtl/core/okvt_pkg.sv @@
// ----------------------------------------------------------------------------
// Ordered key-value table package
// Shared request/result types, command and status codes, control structs.
// ----------------------------------------------------------------------------
`default_nettype none

package okvt_pkg;

	// default sizing
	localparam int DEF_CAPACITY    = 16;
	localparam int DEF_KEY_WIDTH   = 32;
	localparam int DEF_VALUE_WIDTH = 32;

	// request commands
	localparam logic [2:0] CMD_LOOKUP = 3'd0;
	localparam logic [2:0] CMD_READ   = 3'd1;
	localparam logic [2:0] CMD_INSERT = 3'd2;
	localparam logic [2:0] CMD_UPDATE = 3'd3;
	localparam logic [2:0] CMD_UPSERT = 3'd4;
	localparam logic [2:0] CMD_ERASE  = 3'd5;

	// result status codes
	localparam logic [2:0] ST_OK        = 3'd0;
	localparam logic [2:0] ST_NOT_FOUND = 3'd1;
	localparam logic [2:0] ST_DUPLICATE = 3'd2;
	localparam logic [2:0] ST_FULL      = 3'd3;
	localparam logic [2:0] ST_POSITION  = 3'd4;

	// result key/value source
	typedef enum logic {
		SEL_REQ,
		SEL_MEM
	} out_sel_t;

	typedef struct packed {
		logic [2:0]  cmd;
		logic [31:0] key;
		logic [31:0] value;
		logic [3:0]  position;
	} req_t;

	typedef struct packed {
		logic        ok;
		logic [2:0]  status;
		logic [31:0] key_out;
		logic [31:0] value_out;
		logic [4:0]  count;
	} rsp_t;

	// controller -> datapath
	typedef struct packed {
		logic       load;
		logic       walk_init;
		logic       walk_from_hit;
		logic       walk_step;
		logic       shift;
		logic       pos_rd;
		logic       ins;
		logic       upd;
		logic       dec;
		logic       emit;
		logic       ok;
		logic [2:0] status;
		out_sel_t   sel;
	} ctl_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic [2:0] op;
		logic       hit;
		logic       walk_end;
		logic       full;
		logic       pos_ok;
	} ctl_sts_t;

endpackage

`default_nettype wire

@@ rtl/core/okvt_ram.sv @@
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module okvt_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered read, data held while re is low
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

@@ rtl/core/okvt_dp.sv @@
// ----------------------------------------------------------------------------
// Ordered key-value table datapath
// Request registers, key/value RAMs, walk counter, entry count, result reg.
// ----------------------------------------------------------------------------
`default_nettype none

`include "ordered_key_value_table_defines.svh"

module okvt_dp #(
	parameter int CAPACITY    = okvt_pkg::DEF_CAPACITY,
	parameter int KEY_WIDTH   = okvt_pkg::DEF_KEY_WIDTH,
	parameter int VALUE_WIDTH = okvt_pkg::DEF_VALUE_WIDTH
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire okvt_pkg::req_t    req,
	input  wire okvt_pkg::ctl_cmd_t cmd,
	output okvt_pkg::ctl_sts_t     sts,
	output logic                   done,
	output okvt_pkg::rsp_t         rsp
);

	localparam int IDX_W = $clog2(CAPACITY);
	localparam int CNT_W = $clog2(CAPACITY + 1);

	// latched request
	logic [2:0]             op_q;
	logic [KEY_WIDTH-1:0]   key_q;
	logic [VALUE_WIDTH-1:0] value_q;
	logic [3:0]             pos_q;

	// table state and walk
	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] issue_q;
	logic             chk_vld_q;
	logic [IDX_W-1:0] chk_idx_q;

	// result register
	logic           done_q;
	okvt_pkg::rsp_t rsp_q;

	// memory ports
	logic                   rd_en;
	logic [IDX_W-1:0]       rd_addr;
	logic                   key_we;
	logic [IDX_W-1:0]       key_waddr;
	logic [KEY_WIDTH-1:0]   key_wdata;
	logic [KEY_WIDTH-1:0]   key_rdata;
	logic                   val_we;
	logic [IDX_W-1:0]       val_waddr;
	logic [VALUE_WIDTH-1:0] val_wdata;
	logic [VALUE_WIDTH-1:0] val_rdata;

	// helpers
	logic [63:0]        req_key_ext;
	logic [63:0]        req_val_ext;
	logic [63:0]        mem_key_ext;
	logic [63:0]        mem_val_ext;
	logic [63:0]        key_q_ext;
	logic [IDX_W+3:0]   pos_ext;
	logic [IDX_W-1:0]   pos_idx;
	logic [IDX_W-1:0]   tail_idx;
	logic [IDX_W-1:0]   shift_dst;
	logic [CNT_W+4:0]   cnt_ext;
	logic               issue_live;
	logic               shift_wr;

	assign req_key_ext = 64'(req.key);
	assign req_val_ext = 64'(req.value);
	assign mem_key_ext = 64'(key_rdata);
	assign mem_val_ext = 64'(val_rdata);
	assign key_q_ext   = 64'(key_q);
	assign pos_ext     = (IDX_W + 4)'(pos_q);
	assign pos_idx     = pos_ext[IDX_W-1:0];
	assign tail_idx    = count_q[IDX_W-1:0];
	assign shift_dst   = chk_idx_q - IDX_W'(1);
	assign cnt_ext     = (CNT_W + 5)'(count_q);
	assign issue_live  = issue_q < count_q;
	assign shift_wr    = cmd.walk_step & cmd.shift & chk_vld_q;

	// status to controller
	assign sts.op       = op_q;
	assign sts.hit      = chk_vld_q && (key_rdata == key_q);
	assign sts.walk_end = !chk_vld_q && !issue_live;
	assign sts.full     = count_q >= CNT_W'(CAPACITY);
	assign sts.pos_ok   = 16'(pos_q) < 16'(count_q);

	// read port shared by both RAMs
	assign rd_en   = cmd.pos_rd | (cmd.walk_step & issue_live);
	assign rd_addr = cmd.pos_rd ? pos_idx : issue_q[IDX_W-1:0];

	// key RAM write: append at tail or compaction move
	assign key_we    = cmd.ins | shift_wr;
	assign key_waddr = cmd.ins ? tail_idx : shift_dst;
	assign key_wdata = cmd.ins ? key_q : key_rdata;

	// value RAM write: append, in-place update or compaction move
	always_comb begin
		val_we    = cmd.ins | cmd.upd | shift_wr;
		val_waddr = shift_dst;
		val_wdata = val_rdata;
		if (cmd.ins) begin
			val_waddr = tail_idx;
			val_wdata = value_q;
		end else if (cmd.upd) begin
			val_waddr = chk_idx_q;
			val_wdata = value_q;
		end
	end

	okvt_ram #(
		.WIDTH(KEY_WIDTH),
		.DEPTH(CAPACITY)
	) u_key_ram (
		.clk  (clk),
		.we   (key_we),
		.waddr(key_waddr),
		.wdata(key_wdata),
		.re   (rd_en),
		.raddr(rd_addr),
		.rdata(key_rdata)
	);

	okvt_ram #(
		.WIDTH(VALUE_WIDTH),
		.DEPTH(CAPACITY)
	) u_val_ram (
		.clk  (clk),
		.we   (val_we),
		.waddr(val_waddr),
		.wdata(val_wdata),
		.re   (rd_en),
		.raddr(rd_addr),
		.rdata(val_rdata)
	);

	// request capture, keys and values masked to storage width
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q    <= req.cmd;
			key_q   <= req_key_ext[KEY_WIDTH-1:0];
			value_q <= req_val_ext[VALUE_WIDTH-1:0];
			pos_q   <= req.position;
		end
	end

	// entry count, walk control and result strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q   <= '0;
			issue_q   <= '0;
			chk_vld_q <= 1'b0;
			done_q    <= 1'b0;
		end else begin
			done_q <= cmd.emit;
			if (cmd.ins) begin
				count_q <= count_q + CNT_W'(1);
			end else if (cmd.dec) begin
				count_q <= count_q - CNT_W'(1);
			end
			if (cmd.walk_init) begin
				chk_vld_q <= 1'b0;
				issue_q   <= cmd.walk_from_hit ? CNT_W'(chk_idx_q) + CNT_W'(1) : '0;
			end else if (cmd.walk_step) begin
				chk_vld_q <= issue_live;
				if (issue_live) begin
					issue_q <= issue_q + CNT_W'(1);
				end
			end
		end
	end

	// index of the entry whose read data is being checked
	always_ff @(posedge clk) begin
		if (cmd.walk_step && issue_live) begin
			chk_idx_q <= issue_q[IDX_W-1:0];
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			rsp_q.ok     <= cmd.ok;
			rsp_q.status <= cmd.status;
			rsp_q.count  <= cnt_ext[4:0];
			if (cmd.sel == okvt_pkg::SEL_MEM) begin
				rsp_q.key_out   <= mem_key_ext[31:0];
				rsp_q.value_out <= mem_val_ext[31:0];
			end else begin
				rsp_q.key_out   <= key_q_ext[31:0];
				rsp_q.value_out <= '0;
			end
		end
	end

	assign done = done_q;
	assign rsp  = rsp_q;

	`OKVT_ASSERT(a_count_bound, clk, arst_n, count_q <= CNT_W'(CAPACITY))
	`OKVT_ASSERT(a_ins_room, clk, arst_n, cmd.ins |-> (count_q < CNT_W'(CAPACITY)))
	`OKVT_ASSERT(a_shift_dst, clk, arst_n, shift_wr |-> (chk_idx_q != '0))
	`OKVT_ASSERT(a_count_hold, clk, arst_n, (!cmd.ins && !cmd.dec) |=> $stable(count_q))
	`OKVT_ASSERT_NEVER(a_wr_excl, clk, arst_n, (cmd.ins && cmd.upd) || (cmd.ins && shift_wr))

endmodule

`default_nettype wire

@@ rtl/core/okvt_ctrl.sv @@
// ----------------------------------------------------------------------------
// Ordered key-value table controller
// Sequences search, compaction and result emission for one request.
// ----------------------------------------------------------------------------
`default_nettype none

module okvt_ctrl (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	output logic                    busy,
	input  wire okvt_pkg::ctl_sts_t sts,
	output okvt_pkg::ctl_cmd_t      cmd
);

	typedef enum logic [1:0] {
		S_IDLE,
		S_SEARCH,
		S_SHIFT,
		S_DONE
	} state_t;

	state_t              state_q, state_d;
	logic                ok_q, ok_d;
	logic [2:0]          status_q, status_d;
	okvt_pkg::out_sel_t  sel_q, sel_d;

	// next state and datapath commands
	always_comb begin
		state_d  = state_q;
		ok_d     = ok_q;
		status_d = status_q;
		sel_d    = sel_q;
		cmd      = '0;
		case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd.load      = 1'b1;
					cmd.walk_init = 1'b1;
					state_d       = S_SEARCH;
				end
			end
			S_SEARCH: begin
				ok_d     = 1'b0;
				status_d = okvt_pkg::ST_NOT_FOUND;
				sel_d    = okvt_pkg::SEL_REQ;
				case (sts.op)
					okvt_pkg::CMD_READ: begin
						cmd.pos_rd = sts.pos_ok;
						state_d    = S_DONE;
						if (sts.pos_ok) begin
							ok_d     = 1'b1;
							status_d = okvt_pkg::ST_OK;
							sel_d    = okvt_pkg::SEL_MEM;
						end else begin
							status_d = okvt_pkg::ST_POSITION;
						end
					end
					okvt_pkg::CMD_LOOKUP, okvt_pkg::CMD_INSERT, okvt_pkg::CMD_UPDATE,
					okvt_pkg::CMD_UPSERT, okvt_pkg::CMD_ERASE: begin
						if (sts.hit) begin
							// key found at the checked index
							state_d = S_DONE;
							case (sts.op)
								okvt_pkg::CMD_LOOKUP: begin
									ok_d     = 1'b1;
									status_d = okvt_pkg::ST_OK;
									sel_d    = okvt_pkg::SEL_MEM;
								end
								okvt_pkg::CMD_INSERT: begin
									status_d = okvt_pkg::ST_DUPLICATE;
								end
								okvt_pkg::CMD_UPDATE, okvt_pkg::CMD_UPSERT: begin
									cmd.upd  = 1'b1;
									ok_d     = 1'b1;
									status_d = okvt_pkg::ST_OK;
								end
								okvt_pkg::CMD_ERASE: begin
									cmd.walk_init     = 1'b1;
									cmd.walk_from_hit = 1'b1;
									state_d           = S_SHIFT;
								end
								default: begin
									state_d = S_DONE;
								end
							endcase
						end else if (sts.walk_end) begin
							// key absent
							state_d = S_DONE;
							if (sts.op inside {okvt_pkg::CMD_INSERT, okvt_pkg::CMD_UPSERT}) begin
								if (sts.full) begin
									status_d = okvt_pkg::ST_FULL;
								end else begin
									cmd.ins  = 1'b1;
									ok_d     = 1'b1;
									status_d = okvt_pkg::ST_OK;
								end
							end
						end else begin
							cmd.walk_step = 1'b1;
						end
					end
					default: begin
						state_d = S_DONE;
					end
				endcase
			end
			S_SHIFT: begin
				// close the gap one entry per cycle
				cmd.shift = 1'b1;
				if (sts.walk_end) begin
					cmd.dec  = 1'b1;
					ok_d     = 1'b1;
					status_d = okvt_pkg::ST_OK;
					sel_d    = okvt_pkg::SEL_REQ;
					state_d  = S_DONE;
				end else begin
					cmd.walk_step = 1'b1;
				end
			end
			S_DONE: begin
				cmd.emit   = 1'b1;
				cmd.ok     = ok_q;
				cmd.status = status_q;
				cmd.sel    = sel_q;
				state_d    = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// state and held result code
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			ok_q     <= 1'b0;
			status_q <= okvt_pkg::ST_OK;
			sel_q    <= okvt_pkg::SEL_REQ;
		end else begin
			state_q  <= state_d;
			ok_q     <= ok_d;
			status_q <= status_d;
			sel_q    <= sel_d;
		end
	end

	assign busy = (state_q != S_IDLE);

endmodule

`default_nettype wire

@@ rtl/core/ordered_key_value_table.sv @@
// Lookup, insert, update, upsert and erase search the entries in order from the first;
// read by position reads its entry directly. Erase then moves each later entry down one place.
// One request at a time; busy falls as the result strobe shows; results cannot be stalled.
// Reset (arst_n low) empties the table at once; RAM contents are not cleared.
// ----------------------------------------------------------------------------
// Ordered key-value table
// Bounded insertion-ordered map: lookup, read by position, insert, update,
// insert-or-update and erase with gap compaction.
// ----------------------------------------------------------------------------
`default_nettype none

module ordered_key_value_table #(
	parameter int CAPACITY    = okvt_pkg::DEF_CAPACITY,
	parameter int KEY_WIDTH   = okvt_pkg::DEF_KEY_WIDTH,
	parameter int VALUE_WIDTH = okvt_pkg::DEF_VALUE_WIDTH
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           start,
	output logic                busy,
	input  wire okvt_pkg::req_t req,
	output logic                done,
	output okvt_pkg::rsp_t      rsp
);

	okvt_pkg::ctl_cmd_t cmd;
	okvt_pkg::ctl_sts_t sts;

	// sequencing
	okvt_ctrl u_ctrl (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start),
		.busy  (busy),
		.sts   (sts),
		.cmd   (cmd)
	);

	// storage and result
	okvt_dp #(
		.CAPACITY   (CAPACITY),
		.KEY_WIDTH  (KEY_WIDTH),
		.VALUE_WIDTH(VALUE_WIDTH)
	) u_dp (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (req),
		.cmd   (cmd),
		.sts   (sts),
		.done  (done),
		.rsp   (rsp)
	);

endmodule

`default_nettype wire

@@ test/okvt_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Ordered key-value table checker
// Keeps a shadow copy of the table, predicts the result of every accepted
// request and compares each result strobe with the oldest prediction.
// ----------------------------------------------------------------------------
module okvt_checker #(
	parameter int CAPACITY = okvt_pkg::DEF_CAPACITY
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	input  logic           busy,
	input  okvt_pkg::req_t req,
	input  logic           done,
	input  okvt_pkg::rsp_t rsp,
	output int             fail_count,
	output int             in_flight
);
	import okvt_pkg::*;

	// shadow table, entries 0..shadow_count-1 in insertion order
	logic [31:0] shadow_keys [CAPACITY];
	logic [31:0] shadow_values [CAPACITY];
	int          shadow_count;

	rsp_t expected_rsp_q[$];
	int   mismatches;

	// apply one request to the shadow table and return its result
	function automatic rsp_t apply_request(req_t r);
		rsp_t res;
		int   hit_idx;
		bit   hit;
		res.ok        = 1'b0;
		res.status    = ST_NOT_FOUND;
		res.key_out   = r.key;
		res.value_out = '0;
		hit_idx = shadow_count;
		for (int i = shadow_count - 1; i >= 0; i--)
			if (shadow_keys[i] == r.key)
				hit_idx = i;
		hit = (hit_idx < shadow_count);

		case (r.cmd)
			CMD_LOOKUP: begin
				if (hit) begin
					res.ok        = 1'b1;
					res.status    = ST_OK;
					res.value_out = shadow_values[hit_idx];
				end
			end
			CMD_READ: begin
				if (int'(r.position) < shadow_count) begin
					res.ok        = 1'b1;
					res.status    = ST_OK;
					res.key_out   = shadow_keys[r.position];
					res.value_out = shadow_values[r.position];
				end else begin
					res.status = ST_POSITION;
				end
			end
			CMD_INSERT, CMD_UPSERT: begin
				if (hit) begin
					if (r.cmd == CMD_UPSERT) begin
						shadow_values[hit_idx] = r.value;
						res.ok     = 1'b1;
						res.status = ST_OK;
					end else begin
						res.status = ST_DUPLICATE;
					end
				end else if (shadow_count >= CAPACITY) begin
					res.status = ST_FULL;
				end else begin
					shadow_keys[shadow_count]   = r.key;
					shadow_values[shadow_count] = r.value;
					shadow_count++;
					res.ok     = 1'b1;
					res.status = ST_OK;
				end
			end
			CMD_UPDATE: begin
				if (hit) begin
					shadow_values[hit_idx] = r.value;
					res.ok     = 1'b1;
					res.status = ST_OK;
				end
			end
			CMD_ERASE: begin
				// close the gap so the remaining order is kept
				if (hit) begin
					for (int i = hit_idx; i + 1 < shadow_count; i++) begin
						shadow_keys[i]   = shadow_keys[i + 1];
						shadow_values[i] = shadow_values[i + 1];
					end
					shadow_count--;
					res.ok     = 1'b1;
					res.status = ST_OK;
				end
			end
			default: ;  // spare codes: not found, no change
		endcase

		res.count = 5'(shadow_count);
		return res;
	endfunction

	// result strobe is compared before the request taken at the same edge
	always @(posedge clk or negedge arst_n) begin : track
		rsp_t want;
		if (!arst_n) begin
			shadow_count = 0;
			mismatches   = 0;
			expected_rsp_q.delete();
			fail_count <= 0;
			in_flight  <= 0;
		end else begin
			if (done) begin
				if (expected_rsp_q.size() == 0) begin
					if (mismatches < 10)
						$display("%0t: result with no request outstanding: ok=%0d status=%0d key=%h value=%h count=%0d",
							$time, rsp.ok, rsp.status, rsp.key_out, rsp.value_out, rsp.count);
					mismatches++;
				end else begin
					want = expected_rsp_q.pop_front();
					if (rsp.ok !== want.ok || rsp.status !== want.status ||
						rsp.key_out !== want.key_out || rsp.value_out !== want.value_out ||
						rsp.count !== want.count) begin
						if (mismatches < 10) begin
							$display("%0t: result mismatch", $time);
							$display("  expected ok=%0d status=%0d key=%h value=%h count=%0d",
								want.ok, want.status, want.key_out, want.value_out, want.count);
							$display("  actual   ok=%0d status=%0d key=%h value=%h count=%0d",
								rsp.ok, rsp.status, rsp.key_out, rsp.value_out, rsp.count);
						end
						mismatches++;
					end
				end
			end
			if (start && !busy)
				expected_rsp_q.push_back(apply_request(req));
			fail_count <= mismatches;
			in_flight  <= expected_rsp_q.size();
		end
	end

endmodule

@@ test/ordered_key_value_table_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Ordered key-value table testbench
// Directed corner requests, then phases of random requests that fill, churn
// and drain the table; results are checked by the companion checker.
// ----------------------------------------------------------------------------
module ordered_key_value_table_tb;
	import okvt_pkg::*;

	localparam int CAPACITY        = DEF_CAPACITY;
	localparam int RANDOM_REQUESTS = 1250;
	localparam int PHASE_COUNT     = 5;
	localparam int POOL_SIZE       = 20;
	localparam int WATCHDOG_LIMIT  = 1000;
	localparam int DRAIN_CYCLES    = 2 * CAPACITY + 8;

	// command codes the block does not define
	localparam logic [2:0] CMD_SPARE_6 = 3'd6;
	localparam logic [2:0] CMD_SPARE_7 = 3'd7;

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	logic done;
	req_t req;
	rsp_t rsp;

	int fail_count;
	int in_flight;
	int stall_cycles;
	bit quiet;

	logic [31:0] key_pool [POOL_SIZE];

	ordered_key_value_table dut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.req    (req),
		.done   (done),
		.rsp    (rsp)
	);

	okvt_checker #(.CAPACITY(CAPACITY)) table_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.req        (req),
		.done       (done),
		.rsp        (rsp),
		.fail_count (fail_count),
		.in_flight  (in_flight)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// watchdog: cycles with neither a request taken nor a result shown
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			stall_cycles <= 0;
		else if ((start && !busy) || done)
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
	end

	always @(posedge clk) begin
		if (stall_cycles >= WATCHDOG_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	// present one request, wait until taken, then maybe leave a gap
	task automatic issue(input logic [2:0] cmd, input logic [31:0] key,
		input logic [31:0] value, input logic [3:0] position);
		req_t r;
		r.cmd      = cmd;
		r.key      = key;
		r.value    = value;
		r.position = position;
		start <= 1'b1;
		req   <= r;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		if (!quiet && $urandom_range(0, 3) == 0) begin
			// junk on the request bus while start is low
			r.cmd      = 3'($urandom);
			r.key      = $urandom;
			r.value    = $urandom;
			r.position = 4'($urandom);
			start <= 1'b0;
			req   <= r;
			repeat ($urandom_range(1, 18))
				@(posedge clk);
		end
	endtask

	// command mix per phase: fill, churn, drain, fill, churn
	function automatic logic [2:0] pick_cmd(int phase);
		int roll;
		int ins_w;
		int ups_w;
		int era_w;
		case (phase)
			0, 3: begin
				ins_w = 35; ups_w = 20; era_w = 5;
			end
			2: begin
				ins_w = 8; ups_w = 5; era_w = 40;
			end
			default: begin
				ins_w = 20; ups_w = 12; era_w = 18;
			end
		endcase
		roll = $urandom_range(0, 99);
		if (roll < 3)
			return ($urandom_range(0, 1) != 0) ? CMD_SPARE_7 : CMD_SPARE_6;
		roll -= 3;
		if (roll < ins_w)
			return CMD_INSERT;
		roll -= ins_w;
		if (roll < ups_w)
			return CMD_UPSERT;
		roll -= ups_w;
		if (roll < era_w)
			return CMD_ERASE;
		case ($urandom_range(0, 2))
			0:       return CMD_LOOKUP;
			1:       return CMD_READ;
			default: return CMD_UPDATE;
		endcase
	endfunction

	initial begin : stimulus
		int          phase;
		logic [2:0]  cmd;
		logic [31:0] key;

		arst_n = 1'b0;
		start  = 1'b0;
		req    = '0;
		quiet  = 1'b0;
		for (int i = 0; i < POOL_SIZE; i++)
			key_pool[i] = $urandom;
		repeat (7)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty table: every search misses, spare codes do nothing
		issue(CMD_LOOKUP, 32'h0000_0000, 32'hFFFF_FFFF, 4'd0);
		issue(CMD_READ,   32'hFFFF_FFFF, 32'h0000_0000, 4'd0);
		issue(CMD_UPDATE, 32'h1234_5678, 32'h9ABC_DEF0, 4'd0);
		issue(CMD_ERASE,  32'h0000_0000, 32'h0000_0000, 4'd0);
		issue(CMD_SPARE_6, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 4'd15);
		issue(CMD_SPARE_7, 32'h0000_0000, 32'h0000_0000, 4'd0);

		// extreme keys and values, duplicate, both upsert paths
		issue(CMD_INSERT, 32'h0000_0000, 32'hFFFF_FFFF, 4'd0);
		issue(CMD_INSERT, 32'hFFFF_FFFF, 32'h0000_0000, 4'd0);
		issue(CMD_INSERT, 32'h0000_0000, 32'h0000_0001, 4'd0);
		issue(CMD_UPSERT, 32'h0000_0000, 32'hA5A5_A5A5, 4'd0);
		issue(CMD_UPSERT, 32'h5A5A_5A5A, 32'h3C3C_3C3C, 4'd0);
		issue(CMD_LOOKUP, 32'hFFFF_FFFF, 32'h0000_0000, 4'd0);
		issue(CMD_READ,   32'h0000_0000, 32'h0000_0000, 4'd2);
		issue(CMD_READ,   32'h0F0F_0F0F, 32'h0000_0000, 4'd15);
		issue(CMD_UPDATE, 32'hFFFF_FFFF, 32'h8000_0001, 4'd0);

		// erase first entry (compaction), last entry, then empty again
		issue(CMD_ERASE,  32'h0000_0000, 32'h0000_0000, 4'd0);
		issue(CMD_READ,   32'h0000_0000, 32'h0000_0000, 4'd0);
		issue(CMD_ERASE,  32'h5A5A_5A5A, 32'h0000_0000, 4'd0);
		issue(CMD_LOOKUP, 32'h0000_0000, 32'h0000_0000, 4'd0);
		issue(CMD_ERASE,  32'hFFFF_FFFF, 32'h0000_0000, 4'd0);

		// random phases over a small key pool so hits and a full table occur
		for (int n = 0; n < RANDOM_REQUESTS; n++) begin
			phase = n * PHASE_COUNT / RANDOM_REQUESTS;
			quiet = (phase == PHASE_COUNT - 1);
			cmd   = pick_cmd(phase);
			if ($urandom_range(0, 9) == 0)
				key = $urandom;
			else
				key = key_pool[$urandom_range(0, POOL_SIZE - 1)];
			issue(cmd, key, $urandom, 4'($urandom_range(0, 15)));
		end

		start <= 1'b0;
		@(posedge clk);
		while (in_flight != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES)
			@(posedge clk);
		if (fail_count == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule

@@ ordered_key_value_table.f @@
+incdir+rtl/core
rtl/core/okvt_pkg.sv
rtl/core/okvt_ram.sv
rtl/core/okvt_dp.sv
rtl/core/okvt_ctrl.sv
rtl/core/ordered_key_value_table.sv
test/okvt_checker.sv
test/ordered_key_value_table_tb.sv
